@@ hw/rtl/utf8d_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// utf8d_pkg
// Shared types and constants for the UTF-8 decoder with replacement.
// ============================================================================
package utf8d_pkg;

    localparam int CODE_W      = 21;
    localparam int BYTE_W      = 8;
    localparam int PEND_W      = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Replacement character and Latin-1 substitution
    localparam logic [CODE_W-1:0] REPL_CODE    = 21'h00FFFD;
    localparam logic [CODE_W-1:0] LATIN1_MAX   = 21'h0000FF;
    localparam logic [CODE_W-1:0] LATIN1_SUBST = 21'h00003F;

    // Top two bits of a continuation byte
    localparam logic [1:0] CONT_TAG = 2'b10;

    // One decoded result waiting between the front and the back
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } utf8d_item_t;

    // Front to queue write
    typedef struct packed {
        logic        valid;
        utf8d_item_t item;
    } utf8d_push_t;

    // Queue occupancy flags
    typedef struct packed {
        logic full;
        logic empty;
    } utf8d_qstat_t;

endpackage

@@ hw/rtl/utf8d_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// utf8d_if
// Valid/ready channel interfaces for the byte input and the code output.
// ============================================================================
interface utf8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface utf8d_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_value;
    logic        last_of_string;

    modport source (output valid, output code_value, output last_of_string, input ready);
    modport sink   (input valid, input code_value, input last_of_string, output ready);
endinterface

@@ hw/rtl/utf8_decoder_with_replacement.sv @@
`timescale 1ns / 1ps
// ============================================================================
// utf8_decoder_with_replacement
// UTF-8 byte stream to code points, with U+FFFD on malformed input and an
// optional Latin-1 output mode.
//
//   Channel   Dir  Handshake      Payload
//   in_ch     in   valid/ready    in_byte[7:0], end_of_string
//   out_ch    out  valid/ready    code_value[20:0], last_of_string
//   cfg       in   cfg_we         cfg_wdata (latin1_output)
//
// One byte is accepted per cycle while the queue has room; the sequence
// state in the front is the only loop. Results pass through the queue and
// the output register. A two-entry queue and the output register let the
// sink stall without holding off the input until the queue fills. Reset
// clears the sequence state, the queue and the mode register.
// ============================================================================
module utf8_decoder_with_replacement (
    input  logic        clk,
    input  logic        rst_n,
    utf8d_in_if.sink    in_ch,
    utf8d_out_if.source out_ch,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);
    import utf8d_pkg::*;

    utf8d_push_t  push;
    utf8d_qstat_t q_stat;
    utf8d_item_t  head;
    logic         pop;
    logic         busy;

    utf8d_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_stat (q_stat),
        .push   (push),
        .busy   (busy)
    );

    utf8d_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .q_stat (q_stat)
    );

    utf8d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_ch    (out_ch)
    );

`ifndef SYNTH
    // Queue is never full and empty at once
    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    // End of string always leaves the front idle
    a_eos_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.end_of_string) |=> !busy)
        else $error("sequence still pending after end of string");

    // A plain ASCII byte outside a sequence gives a result at once
    a_ascii_push: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && !busy && !in_ch.in_byte[7]) |-> push.valid)
        else $error("ASCII byte produced no result");

    // Nothing is written into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !q_stat.full)
        else $error("push into full queue");
`endif

endmodule

@@ hw/rtl/utf8d_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// utf8d_front
// Accepts bytes, classifies them and tracks the pending sequence; pushes
// each finished code point or replacement into the queue.
// ============================================================================
module utf8d_front (
    input  logic                   clk,
    input  logic                   rst_n,
    utf8d_in_if.sink               in_ch,
    input  utf8d_pkg::utf8d_qstat_t q_stat,
    output utf8d_pkg::utf8d_push_t  push,
    output logic                   busy
);
    import utf8d_pkg::*;

    logic [PEND_W-1:0] pend_reg;
    logic [PEND_W-1:0] pend_next;
    logic [CODE_W-1:0] acc_reg;
    logic [CODE_W-1:0] acc_next;
    logic              accept;
    logic              emit;
    logic [CODE_W-1:0] value;

    // Take a byte whenever the queue has room
    assign in_ch.ready = !q_stat.full;
    assign accept      = in_ch.valid && !q_stat.full;
    assign busy        = (pend_reg != '0);

    // Classify the byte and work out the next sequence state
    always_comb
    begin
        logic [CODE_W-1:0] acc_shift;
        logic [PEND_W-1:0] pend_dec;
        acc_shift = {acc_reg[CODE_W-7:0], in_ch.in_byte[5:0]};
        pend_dec  = pend_reg - 1'b1;
        emit      = 1'b0;
        value     = '0;
        pend_next = pend_reg;
        acc_next  = acc_reg;
        if (pend_reg == '0)
        begin
            case (in_ch.in_byte) inside
                8'b0???????:
                begin
                    emit  = 1'b1;
                    value = {{(CODE_W-BYTE_W){1'b0}}, in_ch.in_byte};
                end
                8'b110?????:
                begin
                    acc_next  = {{(CODE_W-5){1'b0}}, in_ch.in_byte[4:0]};
                    pend_next = 2'd1;
                end
                8'b1110????:
                begin
                    acc_next  = {{(CODE_W-4){1'b0}}, in_ch.in_byte[3:0]};
                    pend_next = 2'd2;
                end
                8'b11110???:
                begin
                    acc_next  = {{(CODE_W-3){1'b0}}, in_ch.in_byte[2:0]};
                    pend_next = 2'd3;
                end
                default:
                begin
                    emit  = 1'b1;
                    value = REPL_CODE;
                end
            endcase
        end
        else if (in_ch.in_byte[7:6] != CONT_TAG)
        begin
            // Interrupted sequence: drop it and consume the byte
            emit      = 1'b1;
            value     = REPL_CODE;
            pend_next = '0;
            acc_next  = '0;
        end
        else
        begin
            pend_next = pend_dec;
            if (pend_dec == '0)
            begin
                emit     = 1'b1;
                value    = acc_shift;
                acc_next = '0;
            end
            else
            begin
                acc_next = acc_shift;
            end
        end

        // Sequence cut short by the end of the string
        if (in_ch.end_of_string && pend_next != '0)
        begin
            emit  = 1'b1;
            value = REPL_CODE;
        end
        if (in_ch.end_of_string)
        begin
            pend_next = '0;
            acc_next  = '0;
        end
    end

    // Advance the sequence state on each transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            acc_reg  <= '0;
        end
        else if (accept)
        begin
            pend_reg <= pend_next;
            acc_reg  <= acc_next;
        end
    end

    assign push.valid     = accept && emit;
    assign push.item.code = value;
    assign push.item.last = in_ch.end_of_string;

endmodule

@@ hw/rtl/utf8d_queue.sv @@
`timescale 1ns / 1ps
// ============================================================================
// utf8d_queue
// Two-entry queue between the front and the back of the decoder.
// ============================================================================
module utf8d_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  utf8d_pkg::utf8d_push_t  push,
    input  logic                    pop,
    output utf8d_pkg::utf8d_item_t  head,
    output utf8d_pkg::utf8d_qstat_t q_stat
);
    import utf8d_pkg::*;

    utf8d_item_t       mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head         = mem_reg[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push.valid && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Write the payload store
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.item;
        end
    end

    // Advance the pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ hw/rtl/utf8d_back.sv @@
`timescale 1ns / 1ps
// ============================================================================
// utf8d_back
// Applies the output mode to queued results and holds them in the output
// register until the sink takes them.
// ============================================================================
module utf8d_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic                    cfg_wdata,
    input  utf8d_pkg::utf8d_item_t  head,
    input  utf8d_pkg::utf8d_qstat_t q_stat,
    output logic                    pop,
    utf8d_out_if.source             out_ch
);
    import utf8d_pkg::*;

    logic              latin1_reg;
    logic              valid_reg;
    logic [CODE_W-1:0] code_reg;
    logic              last_reg;
    logic              load;
    logic [CODE_W-1:0] mapped;

    // Refill the output register when it is empty or being taken
    assign load = !valid_reg || out_ch.ready;
    assign pop  = load && !q_stat.empty;

    // Substitute '?' for values outside Latin-1 in Latin-1 mode
    assign mapped = (latin1_reg && head.code > LATIN1_MAX) ? LATIN1_SUBST : head.code;

    // Hold the mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latin1_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            latin1_reg <= cfg_wdata;
        end
    end

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= !q_stat.empty;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            code_reg <= mapped;
            last_reg <= head.last;
        end
    end

    assign out_ch.valid          = valid_reg;
    assign out_ch.code_value     = code_reg;
    assign out_ch.last_of_string = last_reg;

endmodule

@@ tb/sv/utf8_decoder_with_replacement_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// utf8_decoder_with_replacement_tb
// Self-checking bench for the UTF-8 decoder with replacement. A table of
// directed transactions covers the extremes, every error path and the Latin-1
// mode. Random strings follow, mostly well-formed with some noise. An
// in-bench decoder predicts every code point, and each output transaction
// is checked against it in order, under varying back-pressure on both
// channels.
// ============================================================================
module utf8_decoder_with_replacement_tb;

    import utf8d_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS = 10;

    typedef enum logic [1:0] {ROW_BYTE, ROW_CFG} row_kind_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_CODE} row_chk_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [7:0]  data;
        logic        eos;
        row_chk_t    chk;
        logic [20:0] code;
    } dir_row_t;

    // Directed transactions; a configuration row writes data[0] as the mode
    localparam int NUM_DIRECTED = 26;
    localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
        '{ROW_BYTE, 8'h00, 1'b0, CHK_CODE,  21'h000000},
        '{ROW_BYTE, 8'h7F, 1'b0, CHK_CODE,  21'h00007F},
        '{ROW_BYTE, 8'hC2, 1'b0, CHK_NONE,  21'h000000},
        '{ROW_BYTE, 8'hA9, 1'b0, CHK_MODEL, 21'h000000},
        '{ROW_BYTE, 8'hF4, 1'b0, CHK_NONE,  21'h000000},
        '{ROW_BYTE, 8'h8F, 1'b0, CHK_NONE,  21'h000000},
        '{ROW_BYTE, 8'hBF, 1'b0, CHK_NONE,  21'h000000},
        '{ROW_BYTE, 8'hBF, 1'b0, CHK_MODEL, 21'h000000},
        '{ROW_BYTE, 8'h80, 1'b0, CHK_CODE,  REPL_CODE},
        '{ROW_BYTE, 8'hFF, 1'b0, CHK_CODE,  REPL_CODE},
        '{ROW_BYTE, 8'hE2, 1'b0, CHK_NONE,  21'h000000},
        '{ROW_BYTE, 8'h41, 1'b0, CHK_CODE,  REPL_CODE},
        '{ROW_BYTE, 8'hE2, 1'b1, CHK_CODE,  REPL_CODE},
        '{ROW_BYTE, 8'hE2, 1'b0, CHK_NONE,  21'h000000},
        '{ROW_BYTE, 8'h82, 1'b1, CHK_CODE,  REPL_CODE},
        '{ROW_BYTE, 8'h41, 1'b1, CHK_CODE,  21'h000041},
        '{ROW_CFG,  8'h01, 1'b0, CHK_NONE,  21'h000000},
        '{ROW_BYTE, 8'hC3, 1'b0, CHK_NONE,  21'h000000},
        '{ROW_BYTE, 8'hA9, 1'b0, CHK_MODEL, 21'h000000},
        '{ROW_BYTE, 8'hE2, 1'b0, CHK_NONE,  21'h000000},
        '{ROW_BYTE, 8'h82, 1'b0, CHK_NONE,  21'h000000},
        '{ROW_BYTE, 8'hAC, 1'b1, CHK_CODE,  LATIN1_SUBST},
        '{ROW_BYTE, 8'hE2, 1'b0, CHK_NONE,  21'h000000},
        '{ROW_CFG,  8'h00, 1'b0, CHK_NONE,  21'h000000},
        '{ROW_BYTE, 8'h82, 1'b0, CHK_NONE,  21'h000000},
        '{ROW_BYTE, 8'hAC, 1'b1, CHK_MODEL, 21'h000000}
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    utf8d_in_if  in_ch ();
    utf8d_out_if out_ch ();

    utf8_decoder_with_replacement dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Decoder state mirrored by the bench
    logic [1:0]  seq_left;
    logic [20:0] seq_bits;
    logic        latin_mode;

    utf8d_item_t pending_codes [$];

    row_chk_t    cur_chk;
    logic [20:0] cur_code;
    int          byte_count;
    int          src_idle_pct;
    int          sink_idle_pct;
    logic        sink_hold;
    int          fail_count;
    int          cycle_count;

    // Clock
    always #1 clk = ~clk;

    // Run time guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** utf8_decoder_with_replacement: FAILED **");
            $finish;
        end
    end

    // Decode one byte into the mirrored state; returns 1 when a code is due
    function automatic logic decode_byte(input logic [7:0] b, input logic eos,
                                         output utf8d_item_t res);
        logic        emit;
        logic [20:0] val;
        emit = 1'b0;
        val  = '0;
        if (seq_left == 2'd0)
        begin
            if (!b[7])
            begin
                emit = 1'b1;
                val  = {13'd0, b};
            end
            else if (b[7:5] == 3'b110)
            begin
                seq_bits = {16'd0, b[4:0]};
                seq_left = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                seq_bits = {17'd0, b[3:0]};
                seq_left = 2'd2;
            end
            else if (b[7:3] == 5'b11110)
            begin
                seq_bits = {18'd0, b[2:0]};
                seq_left = 2'd3;
            end
            else
            begin
                emit = 1'b1;
                val  = REPL_CODE;
            end
        end
        else if (b[7:6] != CONT_TAG)
        begin
            // interrupted sequence: the byte is swallowed
            emit     = 1'b1;
            val      = REPL_CODE;
            seq_left = 2'd0;
            seq_bits = '0;
        end
        else
        begin
            seq_bits = {seq_bits[14:0], b[5:0]};
            seq_left = seq_left - 2'd1;
            if (seq_left == 2'd0)
            begin
                emit     = 1'b1;
                val      = seq_bits;
                seq_bits = '0;
            end
        end
        // cut short by the end of the string
        if (eos && seq_left != 2'd0)
        begin
            emit = 1'b1;
            val  = REPL_CODE;
        end
        if (eos)
        begin
            seq_left = 2'd0;
            seq_bits = '0;
        end
        res.code = (latin_mode && val > LATIN1_MAX) ? LATIN1_SUBST : val;
        res.last = eos;
        return emit;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Input monitor: predict on every accepted byte
    always @(posedge clk)
    begin
        utf8d_item_t res;
        logic        emit;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            emit = decode_byte(in_ch.in_byte, in_ch.end_of_string, res);
            if (cur_chk == CHK_CODE)
                pending_codes.push_back({cur_code, in_ch.end_of_string});
            else if (cur_chk == CHK_MODEL && emit)
                pending_codes.push_back(res);
        end
    end

    // Output monitor: compare each accepted code with the oldest expectation
    always @(posedge clk)
    begin
        utf8d_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_codes.size() == 0)
                note_failure($sformatf("unexpected code %06h last %0b",
                                       out_ch.code_value, out_ch.last_of_string));
            else
            begin
                want = pending_codes.pop_front();
                if (out_ch.code_value !== want.code || out_ch.last_of_string !== want.last)
                    note_failure($sformatf("expected code %06h last %0b, got %06h last %0b",
                                           want.code, want.last,
                                           out_ch.code_value, out_ch.last_of_string));
            end
        end
    end

    // Receiver: random back-pressure, forced low during a hold-off
    always @(negedge clk)
        out_ch.ready <= !sink_hold && ($urandom_range(99) >= sink_idle_pct);

    // Hold the receiver off, counted on rising edges
    task automatic hold_sink(input int cycles);
        sink_hold = 1'b1;
        repeat (cycles) @(posedge clk);
        sink_hold = 1'b0;
    endtask

    // Offer one byte, entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic eos,
                             input row_chk_t chk, input logic [20:0] code);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.in_byte       <= b;
        in_ch.end_of_string <= eos;
        cur_chk  = chk;
        cur_code = code;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        byte_count++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected code has arrived
    task automatic drain_codes();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_mode(input logic mode);
        drain_codes();
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        latin_mode = mode;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Build one random string: mostly valid characters, some broken ones
    task automatic send_string(input int nchars);
        logic [7:0] str [$];
        int         sel;
        int         need;
        int         have;
        for (int c = 0; c < nchars; c++)
        begin
            sel = $urandom_range(99);
            if (sel < 30)
                str.push_back(8'($urandom_range(127)));
            else if (sel < 86)
            begin
                // pick the length; the truncated class stops early
                if (sel < 50)
                    need = 1;
                else if (sel < 68)
                    need = 2;
                else if (sel < 80)
                    need = 3;
                else
                    need = $urandom_range(1, 3);
                case (need)
                    1: str.push_back({3'b110, 5'($urandom)});
                    2: str.push_back({4'b1110, 4'($urandom)});
                    default: str.push_back({5'b11110, 3'($urandom)});
                endcase
                have = (sel < 80) ? need : $urandom_range(0, need - 1);
                for (int k = 0; k < have; k++)
                    str.push_back({CONT_TAG, 6'($urandom)});
            end
            else if (sel < 91)
                str.push_back({CONT_TAG, 6'($urandom)});
            else if (sel < 95)
                str.push_back(8'($urandom_range(255, 248)));
            else
                str.push_back(8'($urandom));
        end
        foreach (str[i])
            send_byte(str[i], i == str.size() - 1, CHK_MODEL, '0);
    endtask

    task automatic run_strings(input int nbytes);
        int start;
        start = byte_count;
        while (byte_count - start < nbytes)
            send_string($urandom_range(1, 8));
    endtask

    initial
    begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.in_byte       = '0;
        in_ch.end_of_string = 1'b0;
        out_ch.ready        = 1'b0;
        seq_left            = '0;
        seq_bits            = '0;
        latin_mode          = 1'b0;
        cur_chk             = CHK_MODEL;
        cur_code            = '0;
        byte_count          = 0;
        sink_hold           = 1'b0;
        fail_count          = 0;
        cycle_count         = 0;
        src_idle_pct        = 14;
        sink_idle_pct       = 56;

        // Reset
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table, starting in the reset mode
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            if (DIRECTED[i].kind == ROW_CFG)
                set_mode(DIRECTED[i].data[0]);
            else
                send_byte(DIRECTED[i].data, DIRECTED[i].eos,
                          DIRECTED[i].chk, DIRECTED[i].code);
        end

        // Sender mostly busy, receiver often stalled, Latin-1 output
        set_mode(1'b1);
        run_strings(515);

        // Sender often idle, receiver mostly ready, full code points
        src_idle_pct  = 56;
        sink_idle_pct = 14;
        set_mode(1'b0);
        run_strings(200);
        fork
            hold_sink(60);
        join_none
        run_strings(315);

        // No idling on either side
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        set_mode(1'b1);
        run_strings(250);
        fork
            hold_sink(80);
        join_none
        run_strings(120);
        drain_codes();
        run_strings(145);

        drain_codes();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("** utf8_decoder_with_replacement: PASSED **");
        else
            $display("** utf8_decoder_with_replacement: FAILED **");
        $finish;
    end

endmodule
